// ===== design/lpc_pkg.sv =====
// shared types and constants for the lidar point cluster block
package lpc_pkg;
  localparam logic [1:0] KIND_POINT  = 2'd0;
  localparam logic [1:0] KIND_REPORT = 2'd1;
  localparam logic [1:0] KIND_CLEAR  = 2'd2;
  localparam logic [1:0] KIND_NONE   = 2'd3;
  localparam logic [11:0] RADIUS_RESET = 12'd150;
  localparam logic [15:0] COUNT_MAX = 16'hFFFF;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] point_time_ms;
    logic signed [15:0] point_x_q;
    logic signed [15:0] point_y_q;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  rank;
    logic [5:0]  slot_number;
    logic [15:0] point_count;
    logic [31:0] cluster_time_ms;
    logic signed [15:0] centre_x_q;
    logic signed [15:0] centre_y_q;
    logic        last;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic load;      // capture input item
    logic clr_step;  // clear slot at scan index
    logic scan_step; // evaluate slot at scan index (point or rank)
    logic div_start;
    logic div_step;
    logic commit;    // write joined slot
    logic rank_init;
    logic out_load;  // capture result at rank index
  } lpc_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic empty_hit;
    logic near_hit;
    logic div_done;
  } lpc_sts_t;
endpackage

// ===== design/lpc_if.sv =====
// valid/ready channel interfaces
interface lpc_in_if;
  import lpc_pkg::*;
  logic valid;
  logic ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface lpc_out_if;
  import lpc_pkg::*;
  logic valid;
  logic ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface lpc_cfg_if;
  logic valid;
  logic ready;
  logic [11:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== design/lidar_point_cluster_top_three_core.sv =====
// top level of the lidar point cluster block
// Clusters lidar points into SLOTS slots and reports the three fullest. After reset
// the table is swept clear before in_ready first rises. A point scans slots from
// index 0, one slot per cycle; a join then runs a 34-step serial divider for the
// running mean plus a commit. A clear sweeps the whole table. A report scans the
// whole table and then offers three items, one at a time. One item is worked on at
// a time; in_ready is high when idle, and the radius is written only then.
module lidar_point_cluster_top_three_core #(
  parameter int SLOTS = 16
) (
  input logic clk,
  input logic rst_n,
  lpc_in_if.sink in_ch,
  lpc_out_if.source out_ch,
  lpc_cfg_if.sink cfg_ch
);
  import lpc_pkg::*;
  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  lpc_cmd_t cmd;
  lpc_sts_t sts;
  logic [IW-1:0] idx;
  logic [1:0] rank_idx;
  logic out_last;
  logic [11:0] radius_r;

  // radius register, written only while idle
  assign cfg_ch.ready = in_ch.ready;
  always_ff @(posedge clk) begin
    if (!rst_n) radius_r <= RADIUS_RESET;
    else if (cfg_ch.valid && cfg_ch.ready) radius_r <= cfg_ch.data;
  end

  lpc_ctrl #(.SLOTS(SLOTS), .IW(IW)) u_ctrl (
    .clk, .rst_n,
    .in_valid(in_ch.valid), .in_kind(in_ch.data.kind), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .sts, .cmd, .idx, .rank_idx, .out_last
  );

  lpc_datapath #(.SLOTS(SLOTS), .IW(IW)) u_dp (
    .clk, .cmd, .in_data(in_ch.data), .radius(radius_r),
    .idx, .rank_idx, .out_last, .sts, .out_data(out_ch.data)
  );
endmodule

// ===== design/lpc_datapath.sv =====
// slot table, distance test, serial mean divider and top-three ranking
module lpc_datapath #(
  parameter int SLOTS = 16,
  parameter int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
  input  logic clk,
  input  lpc_pkg::lpc_cmd_t cmd,
  input  lpc_pkg::in_item_t in_data,
  input  logic [11:0] radius,
  input  logic [IW-1:0] idx,
  input  logic [1:0] rank_idx,
  input  logic out_last,
  output lpc_pkg::lpc_sts_t sts,
  output lpc_pkg::out_item_t out_data
);
  import lpc_pkg::*;

  logic [15:0] cnt_r [SLOTS];
  logic [31:0] tim_r [SLOTS];
  logic signed [15:0] x_r [SLOTS];
  logic signed [15:0] y_r [SLOTS];
  in_item_t item_r;
  logic [IW-1:0] hit_r;
  logic [15:0] rc_r [3];
  logic [IW-1:0] rp_r [3];
  out_item_t out_r;

  // current slot through one mux
  logic [15:0] c_cur;
  logic signed [15:0] x_cur, y_cur;
  logic signed [16:0] dx, dy;
  logic signed [33:0] dxx, dyy;
  logic [33:0] d2;
  logic [13:0] r4;
  logic [27:0] lim;
  assign c_cur = cnt_r[idx];
  assign x_cur = x_r[idx];
  assign y_cur = y_r[idx];
  assign dx = 17'(x_cur) - 17'(item_r.point_x_q);
  assign dy = 17'(y_cur) - 17'(item_r.point_y_q);
  assign dxx = dx * dx;
  assign dyy = dy * dy;
  assign d2 = $unsigned(dxx) + $unsigned(dyy);
  assign r4 = {radius, 2'b00};
  assign lim = r4 * r4;
  assign sts.empty_hit = (c_cur == 16'd0);
  assign sts.near_hit = (d2 < 34'(lim));

  // serial signed divide of sums by n+1, both axes in parallel
  logic [33:0] nx_r, ny_r;     // magnitudes, quotient shifts in
  logic [16:0] den_r;
  logic [16:0] remx_r, remy_r;
  logic sx_r, sy_r;
  logic [5:0] dcnt_r;
  logic signed [33:0] px, py;
  logic signed [33:0] sumx, sumy;
  logic [16:0] rx_try, ry_try;
  logic [17:0] rx_sub, ry_sub;
  assign px = $signed({1'b0, c_cur}) * x_cur;
  assign py = $signed({1'b0, c_cur}) * y_cur;
  assign sumx = 34'(item_r.point_x_q) + px;
  assign sumy = 34'(item_r.point_y_q) + py;
  assign rx_try = {remx_r[15:0], nx_r[33]};
  assign ry_try = {remy_r[15:0], ny_r[33]};
  assign rx_sub = {1'b0, rx_try} - {1'b0, den_r};
  assign ry_sub = {1'b0, ry_try} - {1'b0, den_r};
  assign sts.div_done = (dcnt_r == 6'd0);

  logic signed [15:0] qx, qy;
  assign qx = sx_r ? -$signed(nx_r[15:0]) : $signed(nx_r[15:0]);
  assign qy = sy_r ? -$signed(ny_r[15:0]) : $signed(ny_r[15:0]);

  always_ff @(posedge clk) begin
    if (cmd.load) item_r <= in_data;
    if (cmd.div_start) begin
      hit_r <= idx;
      sx_r <= sumx[33];
      sy_r <= sumy[33];
      nx_r <= sumx[33] ? 34'(-sumx) : sumx;
      ny_r <= sumy[33] ? 34'(-sumy) : sumy;
      den_r <= 17'(c_cur) + 17'd1;
      remx_r <= '0;
      remy_r <= '0;
      dcnt_r <= 6'd34;
    end else if (cmd.div_step && dcnt_r != 6'd0) begin
      dcnt_r <= dcnt_r - 6'd1;
      if (!rx_sub[17]) begin
        remx_r <= rx_sub[16:0];
        nx_r <= {nx_r[32:0], 1'b1};
      end else begin
        remx_r <= rx_try;
        nx_r <= {nx_r[32:0], 1'b0};
      end
      if (!ry_sub[17]) begin
        remy_r <= ry_sub[16:0];
        ny_r <= {ny_r[32:0], 1'b1};
      end else begin
        remy_r <= ry_try;
        ny_r <= {ny_r[32:0], 1'b0};
      end
    end
    if (cmd.clr_step) begin
      cnt_r[idx] <= '0;
      tim_r[idx] <= '0;
      x_r[idx] <= '0;
      y_r[idx] <= '0;
    end else if (cmd.scan_step && item_r.kind == KIND_POINT && sts.empty_hit) begin
      cnt_r[idx] <= 16'd1;
      tim_r[idx] <= item_r.point_time_ms;
      x_r[idx] <= item_r.point_x_q;
      y_r[idx] <= item_r.point_y_q;
    end else if (cmd.commit) begin
      if (cnt_r[hit_r] != COUNT_MAX) cnt_r[hit_r] <= cnt_r[hit_r] + 16'd1;
      if (tim_r[hit_r] < item_r.point_time_ms) tim_r[hit_r] <= item_r.point_time_ms;
      x_r[hit_r] <= qx;
      y_r[hit_r] <= qy;
    end
    if (cmd.rank_init) begin
      for (int k = 0; k < 3; k++) begin
        rc_r[k] <= '0;
        rp_r[k] <= '0;
      end
    end else if (cmd.scan_step && item_r.kind == KIND_REPORT) begin
      priority if (c_cur > rc_r[0]) begin
        rc_r[2] <= rc_r[1]; rp_r[2] <= rp_r[1];
        rc_r[1] <= rc_r[0]; rp_r[1] <= rp_r[0];
        rc_r[0] <= c_cur; rp_r[0] <= idx;
      end else if (c_cur > rc_r[1]) begin
        rc_r[2] <= rc_r[1]; rp_r[2] <= rp_r[1];
        rc_r[1] <= c_cur; rp_r[1] <= idx;
      end else if (c_cur > rc_r[2]) begin
        rc_r[2] <= c_cur; rp_r[2] <= idx;
      end
    end
    if (cmd.out_load) begin
      out_r.rank <= rank_idx;
      out_r.slot_number <= 6'(rp_r[rank_idx]);
      out_r.point_count <= cnt_r[rp_r[rank_idx]];
      out_r.cluster_time_ms <= tim_r[rp_r[rank_idx]];
      out_r.centre_x_q <= x_r[rp_r[rank_idx]];
      out_r.centre_y_q <= y_r[rp_r[rank_idx]];
      out_r.last <= out_last;
    end
  end
  assign out_data = out_r;
endmodule

// ===== design/lpc_ctrl.sv =====
// sequencer for scans, divider and result delivery
module lpc_ctrl #(
  parameter int SLOTS = 16,
  parameter int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  input  logic [1:0] in_kind,
  output logic in_ready,
  output logic out_valid,
  input  logic out_ready,
  input  lpc_pkg::lpc_sts_t sts,
  output lpc_pkg::lpc_cmd_t cmd,
  output logic [IW-1:0] idx,
  output logic [1:0] rank_idx,
  output logic out_last
);
  import lpc_pkg::*;
  localparam logic [2:0] S_IDLE = 3'd0, S_PSCAN = 3'd1, S_DIV = 3'd2,
                         S_CLR = 3'd3, S_RSCAN = 3'd4, S_OUT = 3'd5, S_WAIT = 3'd6;
  localparam logic [IW-1:0] LAST_IDX = IW'(SLOTS - 1);
  logic [2:0] state_r, state_nxt;
  logic [IW-1:0] idx_r, idx_nxt;
  logic [1:0] rank_r, rank_nxt;
  logic ov_r, ov_nxt;

  assign idx = idx_r;
  assign rank_idx = rank_r;
  assign out_last = (rank_r == 2'd2);
  assign out_valid = ov_r;
  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    idx_nxt = idx_r;
    rank_nxt = rank_r;
    ov_nxt = ov_r;
    cmd = '0;
    unique case (state_r)
      S_IDLE: if (in_valid) begin
        cmd.load = 1'b1;
        idx_nxt = '0;
        cmd.rank_init = 1'b1;
        priority case (in_kind)
          KIND_POINT:  state_nxt = S_PSCAN;
          KIND_REPORT: state_nxt = S_RSCAN;
          KIND_CLEAR:  state_nxt = S_CLR;
          default:     state_nxt = S_IDLE;
        endcase
      end
      S_PSCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.empty_hit) state_nxt = S_IDLE;
        else if (sts.near_hit) begin
          cmd.div_start = 1'b1;
          state_nxt = S_DIV;
        end else if (idx_r == LAST_IDX) state_nxt = S_IDLE;
        else idx_nxt = idx_r + 1'b1;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_done) begin
          cmd.commit = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_CLR: begin
        cmd.clr_step = 1'b1;
        if (idx_r == LAST_IDX) state_nxt = S_IDLE;
        else idx_nxt = idx_r + 1'b1;
      end
      S_RSCAN: begin
        cmd.scan_step = 1'b1;
        if (idx_r == LAST_IDX) begin
          state_nxt = S_OUT;
          rank_nxt = 2'd0;
        end else idx_nxt = idx_r + 1'b1;
      end
      S_OUT: begin
        cmd.out_load = 1'b1;
        ov_nxt = 1'b1;
        state_nxt = S_WAIT;
      end
      S_WAIT: if (out_ready) begin
        ov_nxt = 1'b0;
        if (rank_r == 2'd2) state_nxt = S_IDLE;
        else begin
          rank_nxt = rank_r + 2'd1;
          state_nxt = S_OUT;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // reset starts a clearing sweep of the slot table
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      idx_r <= '0;
      rank_r <= '0;
      ov_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      idx_r <= idx_nxt;
      rank_r <= rank_nxt;
      ov_r <= ov_nxt;
    end
  end
endmodule

// ===== design/lpc_checker.sv =====
// port-level checks for the cluster block, bound to the top level
module lpc_port_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic [1:0] out_rank,
  input logic out_last
);
  ap_no_in_while_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready) else $error("input taken during report");
  ap_last_rank: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_last == (out_rank == 2'd2))) else $error("last flag mismatch");
  ap_rank_order: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && !out_last) |=> ##1 (out_valid &&
    out_rank == $past(out_rank, 2) + 2'd1)) else $error("rank order");
  ap_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_rank)))
    else $error("result dropped");
endmodule

bind lidar_point_cluster_top_three_core lpc_port_checker u_chk (
  .clk, .rst_n,
  .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .out_rank(out_ch.data.rank), .out_last(out_ch.data.last)
);
